// ===== src/rc4_pkg.sv =====
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int SBOX_DEPTH        = 256;
  localparam int MAX_KEY_BYTES_DEF = 256;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RFILL,
    ST_FILL,
    ST_SCH0,
    ST_SCH1,
    ST_SCH2,
    ST_SCH3,
    ST_SEND,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_K4,
    ST_K5
  } step_t;

  typedef enum logic [1:0] {NX_GOTO, NX_IEND, NX_DISPATCH, NX_OUTWAIT} nx_t;
  typedef enum logic [2:0] {RA_NONE, RA_I, RA_I_INC, RA_J_RD, RA_J_RDK, RA_T} ra_t;
  typedef enum logic [1:0] {WR_NONE, WR_I_I, WR_I_RD, WR_J_SI} wr_t;
  typedef enum logic [1:0] {I_HOLD, I_INC, I_CLR} iop_t;
  typedef enum logic [1:0] {J_HOLD, J_RD, J_RDK, J_CLR} jop_t;

  typedef struct packed {
    nx_t   nx;
    step_t target;
    step_t alt;
    ra_t   ra;
    wr_t   wr;
    iop_t  iop;
    jop_t  jop;
    logic  si_ld;
    logic  sj_ld;
    logic  key_rd;
    logic  kidx_adv;
    logic  key_clr;
    logic  out_ld;
  } ctrl_t;

  typedef struct packed {
    logic i_max;
    logic out_free;
  } stat_t;

  // Microprogram: one control word per step.
  function automatic ctrl_t ucode(step_t pc);
    ctrl_t c;
    c = '0;
    c.nx     = NX_GOTO;
    c.target = ST_IDLE;
    c.alt    = ST_IDLE;
    c.ra     = RA_NONE;
    c.wr     = WR_NONE;
    c.iop    = I_HOLD;
    c.jop    = J_HOLD;
    unique case (pc)
      ST_IDLE: begin
        c.nx = NX_DISPATCH;
      end
      ST_RFILL: begin
        c.wr     = WR_I_I;
        c.iop    = I_INC;
        c.nx     = NX_IEND;
        c.target = ST_IDLE;
        c.alt    = ST_RFILL;
      end
      ST_FILL: begin
        c.wr     = WR_I_I;
        c.iop    = I_INC;
        c.nx     = NX_IEND;
        c.target = ST_SCH0;
        c.alt    = ST_FILL;
      end
      ST_SCH0: begin
        c.ra     = RA_I;
        c.key_rd = 1'b1;
        c.target = ST_SCH1;
      end
      ST_SCH1: begin
        c.si_ld  = 1'b1;
        c.jop    = J_RDK;
        c.ra     = RA_J_RDK;
        c.target = ST_SCH2;
      end
      ST_SCH2: begin
        c.wr     = WR_I_RD;
        c.target = ST_SCH3;
      end
      ST_SCH3: begin
        c.wr       = WR_J_SI;
        c.iop      = I_INC;
        c.kidx_adv = 1'b1;
        c.nx       = NX_IEND;
        c.target   = ST_SEND;
        c.alt      = ST_SCH0;
      end
      ST_SEND: begin
        c.iop     = I_CLR;
        c.jop     = J_CLR;
        c.key_clr = 1'b1;
        c.target  = ST_IDLE;
      end
      ST_K0: begin
        c.iop    = I_INC;
        c.ra     = RA_I_INC;
        c.target = ST_K1;
      end
      ST_K1: begin
        c.si_ld  = 1'b1;
        c.jop    = J_RD;
        c.ra     = RA_J_RD;
        c.target = ST_K2;
      end
      ST_K2: begin
        c.sj_ld  = 1'b1;
        c.wr     = WR_I_RD;
        c.target = ST_K3;
      end
      ST_K3: begin
        c.wr     = WR_J_SI;
        c.target = ST_K4;
      end
      ST_K4: begin
        c.ra     = RA_T;
        c.target = ST_K5;
      end
      ST_K5: begin
        c.out_ld = 1'b1;
        c.nx     = NX_OUTWAIT;
        c.target = ST_IDLE;
        c.alt    = ST_K5;
      end
      default: begin
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/rc4_sequencer.sv =====
`timescale 1ns / 1ps

module rc4_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_kind,
  input  logic            in_last,
  input  rc4_pkg::stat_t  st,
  output rc4_pkg::ctrl_t  ctrl,
  output logic            in_ready
);

  rc4_pkg::step_t pc;
  rc4_pkg::step_t pc_next;
  logic           in_acc;

  assign ctrl     = rc4_pkg::ucode(pc);
  assign in_ready = (ctrl.nx == rc4_pkg::NX_DISPATCH);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rc4_pkg::ST_RFILL;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    pc_next = pc;
    unique case (ctrl.nx)
      rc4_pkg::NX_GOTO: begin
        pc_next = ctrl.target;
      end
      rc4_pkg::NX_IEND: begin
        pc_next = st.i_max ? ctrl.target : ctrl.alt;
      end
      rc4_pkg::NX_OUTWAIT: begin
        pc_next = st.out_free ? ctrl.target : ctrl.alt;
      end
      rc4_pkg::NX_DISPATCH: begin
        if (in_acc) begin
          if (in_kind == rc4_pkg::KIND_DATA) begin
            pc_next = rc4_pkg::ST_K0;
          end else if (in_last) begin
            pc_next = rc4_pkg::ST_FILL;
          end
        end
      end
      default: begin
        pc_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  a_data_starts_gen: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_kind == rc4_pkg::KIND_DATA) |=> pc == rc4_pkg::ST_K0)
    else $error("data request did not start the generator");

  a_last_key_starts_sched: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_kind == rc4_pkg::KIND_KEY && in_last) |=> pc == rc4_pkg::ST_FILL)
    else $error("final key byte did not start the schedule");

  a_sched_loops: assert property (@(posedge clk) disable iff (rst)
    (pc == rc4_pkg::ST_SCH3 && !st.i_max) |=> pc == rc4_pkg::ST_SCH0)
    else $error("schedule left its loop early");

  a_out_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (pc == rc4_pkg::ST_K5 && !st.out_free) |=> pc == rc4_pkg::ST_K5)
    else $error("result dropped while output was full");

endmodule

// ===== src/rc4_datapath.sv =====
`timescale 1ns / 1ps

module rc4_datapath #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rc4_pkg::ctrl_t             ctrl,
  input  logic                       in_acc,
  input  logic                       in_kind,
  input  logic [rc4_pkg::BYTE_W-1:0] in_value,
  input  logic                       in_last,
  output rc4_pkg::stat_t             st,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rc4_pkg::BYTE_W-1:0] out_value,
  output logic                       out_last
);

  localparam int CW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  rc4_pkg::byte_t sbox [rc4_pkg::SBOX_DEPTH];
  rc4_pkg::byte_t key_store [MAX_KEY_BYTES];

  rc4_pkg::byte_t i, i_next;
  rc4_pkg::byte_t j, j_next;
  rc4_pkg::byte_t rd;
  rc4_pkg::byte_t key_q;
  rc4_pkg::byte_t si;
  rc4_pkg::byte_t sj;
  rc4_pkg::byte_t dbyte;
  logic           dlast;
  logic [CW-1:0]  key_count;
  logic [KW-1:0]  kidx;
  logic [CW-1:0]  key_len;
  logic           kidx_wrap;
  logic           key_acc;
  logic           key_wr;

  rc4_pkg::byte_t j_rd, j_rdk;
  rc4_pkg::byte_t ra, wa, wd;
  logic           re, we;

  assign j_rd  = j + rd;
  assign j_rdk = j_rd + key_q;

  assign key_acc = in_acc && (in_kind == rc4_pkg::KIND_KEY);
  assign key_wr  = key_acc && (key_count < CW'(MAX_KEY_BYTES));

  // An empty key behaves as length one.
  assign key_len   = (key_count == '0) ? CW'(1) : key_count;
  assign kidx_wrap = (CW'(kidx) + CW'(1)) == key_len;

  assign st.i_max    = (i == rc4_pkg::byte_t'(rc4_pkg::SBOX_DEPTH - 1));
  assign st.out_free = !out_valid || out_ready;

  always_comb begin
    re = 1'b1;
    ra = i;
    unique case (ctrl.ra)
      rc4_pkg::RA_NONE:  re = 1'b0;
      rc4_pkg::RA_I:     ra = i;
      rc4_pkg::RA_I_INC: ra = i + 8'd1;
      rc4_pkg::RA_J_RD:  ra = j_rd;
      rc4_pkg::RA_J_RDK: ra = j_rdk;
      rc4_pkg::RA_T:     ra = si + sj;
      default:           re = 1'b0;
    endcase
  end

  always_comb begin
    we = 1'b1;
    wa = i;
    wd = i;
    unique case (ctrl.wr)
      rc4_pkg::WR_NONE: we = 1'b0;
      rc4_pkg::WR_I_I: begin
        wa = i;
        wd = i;
      end
      rc4_pkg::WR_I_RD: begin
        wa = i;
        wd = rd;
      end
      rc4_pkg::WR_J_SI: begin
        wa = j;
        wd = si;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    i_next = i;
    unique case (ctrl.iop)
      rc4_pkg::I_HOLD: i_next = i;
      rc4_pkg::I_INC:  i_next = i + 8'd1;
      rc4_pkg::I_CLR:  i_next = '0;
      default:         i_next = i;
    endcase
    j_next = j;
    unique case (ctrl.jop)
      rc4_pkg::J_HOLD: j_next = j;
      rc4_pkg::J_RD:   j_next = j_rd;
      rc4_pkg::J_RDK:  j_next = j_rdk;
      rc4_pkg::J_CLR:  j_next = '0;
      default:         j_next = j;
    endcase
    // The final key byte resets both indices before the box is refilled.
    if (key_acc && in_last) begin
      i_next = '0;
      j_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sbox[wa] <= wd;
    end
    if (re) begin
      rd <= sbox[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_store[key_count[KW-1:0]] <= in_value;
    end
    if (ctrl.key_rd) begin
      key_q <= key_store[kidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= '0;
      j         <= '0;
      key_count <= '0;
      kidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      i <= i_next;
      j <= j_next;
      if (ctrl.key_clr) begin
        key_count <= '0;
        kidx      <= '0;
      end else begin
        if (key_wr) begin
          key_count <= key_count + CW'(1);
        end
        if (ctrl.kidx_adv) begin
          kidx <= kidx_wrap ? '0 : kidx + KW'(1);
        end
      end
      if (ctrl.out_ld && st.out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.si_ld) begin
      si <= rd;
    end
    if (ctrl.sj_ld) begin
      sj <= rd;
    end
    if (in_acc && in_kind == rc4_pkg::KIND_DATA) begin
      dbyte <= in_value;
      dlast <= in_last;
    end
    if (ctrl.out_ld && st.out_free) begin
      out_value <= dbyte ^ rd;
      out_last  <= dlast;
    end
  end

  a_key_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CW'(MAX_KEY_BYTES))
    else $error("key count ran past the key store");

endmodule

// ===== src/rc4_stream_cipher_top.sv =====
`timescale 1ns / 1ps
// Data request: the sequencer steps K0 to K5 and registers the result at K5, where it
// waits while the output is full; the next request is taken only back in IDLE. The S-box
// memory serves the reads and swap writes in turn. Key byte: taken in IDLE. Final key
// byte: identity fill, then SCH0 to SCH3 for each of 256 swaps, then one clean-up step
// before the next request. Reset (synchronous, active high) starts an identity fill of the S-box
// during which no request is accepted; indices and key count come up at zero.
module rc4_stream_cipher_top #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rc4_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] value
  input  logic                       s_axis_tuser,  // [0] kind
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [rc4_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] value_out
  output logic                       m_axis_tlast
);

  rc4_pkg::ctrl_t ctrl;
  rc4_pkg::stat_t st;
  logic           in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  rc4_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .st       (st),
    .ctrl     (ctrl),
    .in_ready (s_axis_tready)
  );

  rc4_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_acc    (in_acc),
    .in_kind   (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
